>>> rtl/tslf_pkg.sv
`default_nettype none
package tslf_pkg;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam int DRIVE_BITS = 9;
  localparam int DIST_BITS = 17;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_CRUISE_LEFT = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CRUISE_RIGHT = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MARKER_DISTANCE = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MARKER_HOLD = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_STOP_CONFIRM = 3'd4;

  localparam logic [7:0] CRUISE_LEFT_RESET = 8'd255;
  localparam logic [7:0] CRUISE_RIGHT_RESET = 8'd255;
  localparam logic [15:0] MARKER_DISTANCE_RESET = 16'd110;
  localparam logic [15:0] MARKER_HOLD_RESET = 16'd2000;
  localparam logic [15:0] STOP_CONFIRM_RESET = 16'd40;

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_TICK = 2'd1;
  localparam logic [1:0] MODE_ENC_RIGHT = 2'd2;
  localparam logic [1:0] MODE_ENC_LEFT = 2'd3;

  localparam logic [1:0] PAT_NONE = 2'b00;
  localparam logic [1:0] PAT_RIGHT_ONLY = 2'b01;
  localparam logic [1:0] PAT_LEFT_ONLY = 2'b10;
  localparam logic [1:0] PAT_BOTH = 2'b11;

  localparam logic signed [DRIVE_BITS-1:0] TURN_BACK = -9'sd150;
  localparam logic signed [DRIVE_BITS-1:0] TURN_SOFT = 9'sd200;
  localparam logic signed [DRIVE_BITS-1:0] TURN_FULL = 9'sd255;

  localparam logic [16:0] DIST_Q16 = 17'd66913;
  localparam logic [15:0] DIST_MAX = 16'd33456;

  typedef enum logic [1:0] {
    DIR_STRAIGHT = 2'd0,
    DIR_LEFT = 2'd1,
    DIR_RIGHT = 2'd2
  } dir_t;

  typedef struct packed {
    logic [7:0] cruise_left;
    logic [7:0] cruise_right;
    logic [15:0] marker_distance;
    logic [15:0] marker_hold;
    logic [15:0] stop_confirm;
  } cfg_t;

  typedef struct packed {
    logic [1:0] mode;
    logic sensor_left;
    logic sensor_right;
  } item_t;

  typedef struct packed {
    logic signed [DRIVE_BITS-1:0] drive_left;
    logic signed [DRIVE_BITS-1:0] drive_right;
    logic running;
    logic signed [DIST_BITS-1:0] distance_cm;
  } status_t;

endpackage
`default_nettype wire

>>> rtl/tslf_item_if.sv
`default_nettype none
interface tslf_item_if;
  logic valid;
  logic ready;
  logic [1:0] mode;
  logic sensor_left;
  logic sensor_right;

  modport source(output valid, mode, sensor_left, sensor_right, input ready);
  modport sink(input valid, mode, sensor_left, sensor_right, output ready);
endinterface
`default_nettype wire

>>> rtl/tslf_result_if.sv
`default_nettype none
interface tslf_result_if;
  logic valid;
  logic ready;
  logic signed [8:0] drive_left;
  logic signed [8:0] drive_right;
  logic running;
  logic signed [16:0] distance_cm;

  modport source(output valid, drive_left, drive_right, running, distance_cm, input ready);
  modport sink(input valid, drive_left, drive_right, running, distance_cm, output ready);
endinterface
`default_nettype wire

>>> rtl/tslf_cfg_regs.sv
`default_nettype none
module tslf_cfg_regs (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [tslf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [tslf_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output tslf_pkg::cfg_t cfg
);
  import tslf_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cruise_left <= CRUISE_LEFT_RESET;
      cfg.cruise_right <= CRUISE_RIGHT_RESET;
      cfg.marker_distance <= MARKER_DISTANCE_RESET;
      cfg.marker_hold <= MARKER_HOLD_RESET;
      cfg.stop_confirm <= STOP_CONFIRM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CRUISE_LEFT: cfg.cruise_left <= cfg_data[7:0];
        CFG_CRUISE_RIGHT: cfg.cruise_right <= cfg_data[7:0];
        CFG_MARKER_DISTANCE: cfg.marker_distance <= cfg_data;
        CFG_MARKER_HOLD: cfg.marker_hold <= cfg_data;
        CFG_STOP_CONFIRM: cfg.stop_confirm <= cfg_data;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> rtl/tslf_distance.sv
`default_nettype none
module tslf_distance #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic signed [COUNT_BITS-1:0] count_left,
  input  wire logic signed [COUNT_BITS-1:0] count_right,
  output logic signed [tslf_pkg::DIST_BITS-1:0] distance_cm
);
  import tslf_pkg::*;

  localparam int PW = COUNT_BITS + 17;
  localparam int QW = PW - 16;
  localparam int CW = (QW > 16) ? QW : 16;

  logic signed [COUNT_BITS:0] sum;
  logic signed [COUNT_BITS:0] sum_adj;
  logic signed [COUNT_BITS-1:0] avg;
  logic [COUNT_BITS-1:0] mag;
  logic [PW-1:0] prod;
  logic [QW-1:0] q;
  logic [15:0] q_sat;
  logic signed [DIST_BITS-1:0] dist_pos;

  always_comb begin
    sum = {count_left[COUNT_BITS-1], count_left} + {count_right[COUNT_BITS-1], count_right};
    // round the halving toward zero
    sum_adj = sum + {{COUNT_BITS{1'b0}}, sum[COUNT_BITS]};
    avg = sum_adj[COUNT_BITS:1];
    mag = avg[COUNT_BITS-1] ? (~avg + 1'b1) : avg;
    prod = PW'(mag) * PW'(DIST_Q16);
    q = prod[PW-1:16];
    q_sat = (CW'(q) > CW'(DIST_MAX)) ? DIST_MAX : 16'(q);
    dist_pos = $signed({1'b0, q_sat});
    distance_cm = avg[COUNT_BITS-1] ? -dist_pos : dist_pos;
  end
endmodule
`default_nettype wire

>>> rtl/tslf_core.sv
`default_nettype none
module tslf_core #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic step,
  input  tslf_pkg::item_t item,
  input  tslf_pkg::cfg_t cfg,
  output tslf_pkg::status_t status
);
  import tslf_pkg::*;

  localparam logic signed [COUNT_BITS-1:0] COUNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
  localparam logic signed [COUNT_BITS-1:0] COUNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

  logic run_active, run_active_next;
  dir_t last_direction, last_direction_next;
  logic signed [DRIVE_BITS-1:0] command_left, command_left_next;
  logic signed [DRIVE_BITS-1:0] command_right, command_right_next;
  logic signed [DRIVE_BITS-1:0] applied_left, applied_left_next;
  logic signed [DRIVE_BITS-1:0] applied_right, applied_right_next;
  logic signed [COUNT_BITS-1:0] count_left, count_left_next;
  logic signed [COUNT_BITS-1:0] count_right, count_right_next;
  logic signed [DIST_BITS-1:0] distance_reg, distance_reg_next;
  logic [31:0] time_now, time_now_next;
  logic [31:0] marker_time, marker_time_next;
  logic [31:0] stop_time, stop_time_next;
  logic marker_taken, marker_taken_next;
  logic marker_done, marker_done_next;
  logic distance_frozen, distance_frozen_next;
  logic stop_pending, stop_pending_next;

  logic signed [DIST_BITS-1:0] dist_calc;
  logic signed [DIST_BITS-1:0] dist_now;
  logic [31:0] t_inc;
  logic [31:0] mt_now;
  logic [1:0] pattern;
  logic left_fwd;
  logic right_fwd;

  tslf_distance #(
    .COUNT_BITS(COUNT_BITS)
  ) u_distance (
    .count_left(count_left),
    .count_right(count_right),
    .distance_cm(dist_calc)
  );

  always_comb begin
    run_active_next = run_active;
    last_direction_next = last_direction;
    command_left_next = command_left;
    command_right_next = command_right;
    applied_left_next = applied_left;
    applied_right_next = applied_right;
    count_left_next = count_left;
    count_right_next = count_right;
    distance_reg_next = distance_reg;
    time_now_next = time_now;
    marker_time_next = marker_time;
    stop_time_next = stop_time;
    marker_taken_next = marker_taken;
    marker_done_next = marker_done;
    distance_frozen_next = distance_frozen;
    stop_pending_next = stop_pending;

    t_inc = time_now + 32'd1;
    dist_now = distance_frozen ? distance_reg : dist_calc;
    mt_now = (!marker_done && !marker_taken) ? t_inc : marker_time;
    pattern = {item.sensor_left, item.sensor_right};
    left_fwd = !command_left[DRIVE_BITS-1] && (command_left != '0);
    right_fwd = !command_right[DRIVE_BITS-1] && (command_right != '0);

    case (item.mode)
      MODE_START: begin
        count_left_next = '0;
        count_right_next = '0;
        distance_reg_next = '0;
        time_now_next = '0;
        marker_time_next = '0;
        stop_time_next = '0;
        marker_taken_next = 1'b0;
        marker_done_next = 1'b0;
        distance_frozen_next = 1'b0;
        stop_pending_next = 1'b0;
        last_direction_next = DIR_STRAIGHT;
        run_active_next = 1'b1;
      end
      MODE_TICK: begin
        if (run_active) begin
          time_now_next = t_inc;
          distance_reg_next = dist_now;
          marker_time_next = mt_now;
          if (!marker_done && !marker_taken &&
              ($signed({dist_now[DIST_BITS-1], dist_now}) >=
               $signed({2'b00, cfg.marker_distance}))) begin
            marker_taken_next = 1'b1;
          end else if (marker_taken && ((t_inc - mt_now) < {16'd0, cfg.marker_hold})) begin
            distance_reg_next = $signed({1'b0, cfg.marker_distance});
            applied_left_next = '0;
            applied_right_next = '0;
            marker_done_next = 1'b1;
            distance_frozen_next = 1'b1;
          end else begin
            distance_frozen_next = 1'b0;
            case (pattern)
              PAT_BOTH: begin
                case (last_direction)
                  DIR_LEFT: begin
                    command_left_next = TURN_BACK;
                    command_right_next = TURN_FULL;
                  end
                  DIR_RIGHT: begin
                    command_left_next = TURN_FULL;
                    command_right_next = TURN_BACK;
                  end
                  default: begin
                    command_left_next = $signed({1'b0, cfg.cruise_left});
                    command_right_next = $signed({1'b0, cfg.cruise_right});
                    last_direction_next = DIR_STRAIGHT;
                  end
                endcase
                stop_pending_next = 1'b0;
              end
              PAT_LEFT_ONLY: begin
                command_left_next = TURN_FULL;
                command_right_next = TURN_SOFT;
                last_direction_next = DIR_RIGHT;
                stop_pending_next = 1'b0;
              end
              PAT_RIGHT_ONLY: begin
                command_left_next = TURN_SOFT;
                command_right_next = TURN_FULL;
                last_direction_next = DIR_LEFT;
                stop_pending_next = 1'b0;
              end
              default: begin
                if (stop_pending && ((t_inc - stop_time) > {16'd0, cfg.stop_confirm})) begin
                  command_left_next = '0;
                  command_right_next = '0;
                  run_active_next = 1'b0;
                end else if (!stop_pending) begin
                  stop_pending_next = 1'b1;
                  stop_time_next = t_inc;
                end
              end
            endcase
            applied_left_next = command_left_next;
            applied_right_next = command_right_next;
          end
        end
      end
      MODE_ENC_RIGHT: begin
        if (right_fwd) begin
          if (count_right != COUNT_MAX) count_right_next = count_right + 1'b1;
        end else begin
          if (count_right != COUNT_MIN) count_right_next = count_right - 1'b1;
        end
      end
      default: begin
        if (left_fwd) begin
          if (count_left != COUNT_MAX) count_left_next = count_left + 1'b1;
        end else begin
          if (count_left != COUNT_MIN) count_left_next = count_left - 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_active <= 1'b0;
      last_direction <= DIR_STRAIGHT;
      command_left <= '0;
      command_right <= '0;
      applied_left <= '0;
      applied_right <= '0;
      count_left <= '0;
      count_right <= '0;
      distance_reg <= '0;
      time_now <= '0;
      marker_time <= '0;
      stop_time <= '0;
      marker_taken <= 1'b0;
      marker_done <= 1'b0;
      distance_frozen <= 1'b0;
      stop_pending <= 1'b0;
    end else if (step) begin
      run_active <= run_active_next;
      last_direction <= last_direction_next;
      command_left <= command_left_next;
      command_right <= command_right_next;
      applied_left <= applied_left_next;
      applied_right <= applied_right_next;
      count_left <= count_left_next;
      count_right <= count_right_next;
      distance_reg <= distance_reg_next;
      time_now <= time_now_next;
      marker_time <= marker_time_next;
      stop_time <= stop_time_next;
      marker_taken <= marker_taken_next;
      marker_done <= marker_done_next;
      distance_frozen <= distance_frozen_next;
      stop_pending <= stop_pending_next;
    end
  end

  assign status.drive_left = applied_left;
  assign status.drive_right = applied_right;
  assign status.running = run_active;
  assign status.distance_cm = distance_reg;
endmodule
`default_nettype wire

>>> rtl/two_sensor_line_follower.sv
// Two-sensor line-follower drive controller.
// item: one beat per event (start, 1 ms tick with both IR levels, right or
// left encoder edge). result: one beat per item, carrying the drive last
// applied to each wheel, the run flag and the distance estimate.
// cfg_we/cfg_index/cfg_data write the five settings; write only while idle.
// A beat taken lands in the input register; its result is then written into
// the state registers. Throughput: one item per cycle while the receiver
// takes each result, set by the single pass through the controller logic
// (one 17-bit constant multiply for the distance) between the input register
// and the state registers, which also hold the result.
// While a result waits, one further item is taken into the input register;
// ready then falls until the receiver takes the result.
// Reset: settings return to their defaults, all run state, counts and
// distance clear to zero, and both registers empty.
`default_nettype none
module two_sensor_line_follower #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  tslf_item_if.sink item,
  tslf_result_if.source result,
  input  wire logic cfg_we,
  input  wire logic [tslf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [tslf_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import tslf_pkg::*;

  cfg_t cfg;
  item_t in_item;
  status_t status;
  logic in_valid;
  logic res_valid;
  logic advance;

  tslf_cfg_regs u_cfg_regs (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cfg(cfg)
  );

  assign advance = in_valid && (!res_valid || result.ready);
  assign item.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (item.ready) in_valid <= item.valid;
      if (advance) res_valid <= 1'b1;
      else if (result.ready) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_item.mode <= item.mode;
      in_item.sensor_left <= item.sensor_left;
      in_item.sensor_right <= item.sensor_right;
    end
  end

  tslf_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .step(advance),
    .item(in_item),
    .cfg(cfg),
    .status(status)
  );

  assign result.valid = res_valid;
  assign result.drive_left = status.drive_left;
  assign result.drive_right = status.drive_right;
  assign result.running = status.running;
  assign result.distance_cm = status.distance_cm;
endmodule
`default_nettype wire
